/* hw/rtl/edp_pkg.sv */
// ----------------------------------------------------------------------------
// edp_pkg
// shared types, widths and decode helpers for the e2m1 x int4 dot product
// ----------------------------------------------------------------------------
package edp_pkg;

  localparam int unsigned ActW   = 4;
  localparam int unsigned NibW   = 4;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned LoW    = 21;
  localparam int unsigned HiW    = 19;
  localparam int unsigned SumW   = 22;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned MantW  = 24;
  localparam int unsigned ExpW   = 10;
  localparam int unsigned ProdW  = 2 * MantW;

  // exponent that makes an integer mantissa read as its own value
  localparam logic [ExpW-1:0] IntExp = ExpW'(150);

  localparam logic [31:0] F32Nan = 32'h7FC0_0000;
  localparam logic [31:0] F32Inf = 32'h7F80_0000;

  // unpacked float operand, mant may be unnormalized
  typedef struct packed {
    logic             sign;
    logic [ExpW-1:0]  exp;
    logic [MantW-1:0] mant;
    logic             is_nan;
    logic             is_inf;
    logic             is_zero;
  } fop_t;

  // weight split q = lo + 8*hi
  typedef struct packed {
    logic signed [3:0] lo;
    logic signed [1:0] hi;
  } wsplit_t;

  typedef struct packed {
    logic acc_en;
    logic last_en;
    logic op_sel;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_ready;
  } stat_t;

  function automatic wsplit_t decode_weight(input logic [NibW-1:0] nib);
    logic signed [4:0] q;
    wsplit_t r;
    unique case (nib[2:0])
      3'd0:    q = 5'sd0;
      3'd1:    q = 5'sd1;
      3'd2:    q = 5'sd2;
      3'd3:    q = 5'sd3;
      3'd4:    q = 5'sd4;
      3'd5:    q = 5'sd6;
      3'd6:    q = 5'sd8;
      default: q = 5'sd12;
    endcase
    if (nib[3]) begin
      q = -q;
    end
    if (q >= 5'sd8) begin
      r.hi = 2'sd1;
      r.lo = 4'(q - 5'sd8);
    end else if (q <= -5'sd8) begin
      r.hi = -2'sd1;
      r.lo = 4'(q + 5'sd8);
    end else begin
      r.hi = 2'sd0;
      r.lo = 4'(q);
    end
    return r;
  endfunction

  function automatic fop_t unpack_f32(input logic [31:0] b);
    fop_t r;
    r.sign    = b[31];
    r.exp     = (b[30:23] == 8'd0) ? ExpW'(1) : ExpW'(b[30:23]);
    r.mant    = {(b[30:23] != 8'd0), b[22:0]};
    r.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.is_zero = (b[30:0] == 31'd0);
    return r;
  endfunction

endpackage

/* hw/rtl/edp_if.sv */
// ----------------------------------------------------------------------------
// edp_in_if / edp_out_if
// valid/ready channels for items and results of the dot product unit
// ----------------------------------------------------------------------------
interface edp_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [edp_pkg::ActW-1:0] act;
  logic [edp_pkg::NibW-1:0]        weight_nibble;
  logic                            last;
  logic [edp_pkg::ScaleW-1:0]      row_scale;
  logic [edp_pkg::ScaleW-1:0]      col_scale;

  modport source (output valid, act, weight_nibble, last, row_scale, col_scale,
                  input ready);
  modport sink (input valid, act, weight_nibble, last, row_scale, col_scale,
                output ready);
endinterface

interface edp_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [edp_pkg::SumW-1:0] dot_sum;
  logic [edp_pkg::HalfW-1:0]       half_result;

  modport source (output valid, dot_sum, half_result, input ready);
  modport sink (input valid, dot_sum, half_result, output ready);
endinterface

/* hw/rtl/edp_fmul.sv */
// ----------------------------------------------------------------------------
// edp_fmul
// three stage float32 multiplier, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module edp_fmul (
  input  logic                clk_i,
  input  edp_pkg::fop_t       op_a_i,
  input  edp_pkg::fop_t       op_b_i,
  output logic [31:0]         res_o
);

  localparam int unsigned PW = edp_pkg::ProdW;

  // stage 1: mantissa product
  logic [PW-1:0]      prod_q;
  logic signed [11:0] e1_q;
  logic               s1_q, nan1_q, inf1_q, zero1_q;

  always_ff @(posedge clk_i) begin
    prod_q  <= op_a_i.mant * op_b_i.mant;
    e1_q    <= $signed({2'b00, op_a_i.exp}) + $signed({2'b00, op_b_i.exp}) - 12'sd127;
    s1_q    <= op_a_i.sign ^ op_b_i.sign;
    nan1_q  <= op_a_i.is_nan | op_b_i.is_nan |
               (op_a_i.is_inf & op_b_i.is_zero) | (op_a_i.is_zero & op_b_i.is_inf);
    inf1_q  <= op_a_i.is_inf | op_b_i.is_inf;
    zero1_q <= op_a_i.is_zero | op_b_i.is_zero;
  end

  // stage 2: leading one and left normalize
  logic [5:0]         lead;
  logic [PW-1:0]      norm_d, norm_q;
  logic signed [11:0] e2_d, e2_q;
  logic               s2_q, nan2_q, inf2_q, zero2_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < PW; i++) begin
      if (prod_q[i]) begin
        lead = 6'(i);
      end
    end
    norm_d = prod_q << (6'(PW - 1) - lead);
    e2_d   = e1_q + $signed({6'd0, lead}) - 12'sd46;
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= norm_d;
    e2_q    <= e2_d;
    s2_q    <= s1_q;
    nan2_q  <= nan1_q;
    inf2_q  <= inf1_q;
    zero2_q <= zero1_q | (prod_q == '0);
  end

  // stage 3: denormalize, round, pack
  logic [5:0]         rsh;
  logic [2*PW-1:0]    wide;
  logic [23:0]        m24;
  logic               rnd;
  logic [7:0]         exp_f;
  logic [31:0]        packed_v;
  logic [31:0]        res_d, res_q;
  logic signed [11:0] rsh_full;

  always_comb begin
    rsh_full = 12'sd1 - e2_q;
    if (e2_q >= 12'sd1) begin
      rsh = '0;
    end else if (rsh_full > 12'sd48) begin
      rsh = 6'd48;
    end else begin
      rsh = rsh_full[5:0];
    end
    wide     = {norm_q, {PW{1'b0}}} >> rsh;
    m24      = wide[2*PW-1 -: 24];
    rnd      = wide[2*PW-25] & ((|wide[2*PW-26:0]) | m24[0]);
    exp_f    = (e2_q >= 12'sd1) ? e2_q[7:0] : 8'd0;
    packed_v = {1'b0, exp_f, m24[22:0]} + {31'd0, rnd};
    priority if (nan2_q) begin
      res_d = edp_pkg::F32Nan;
    end else if (inf2_q) begin
      res_d = {s2_q, edp_pkg::F32Inf[30:0]};
    end else if (zero2_q) begin
      res_d = {s2_q, 31'd0};
    end else if (e2_q >= 12'sd255) begin
      res_d = {s2_q, edp_pkg::F32Inf[30:0]};
    end else begin
      res_d = {s2_q, packed_v[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/edp_datapath.sv */
// ----------------------------------------------------------------------------
// edp_datapath
// accumulators, scale registers, shared float multiplier, output register
// ----------------------------------------------------------------------------
module edp_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  edp_pkg::cmd_t                    cmd_i,
  input  logic signed [edp_pkg::ActW-1:0]  act_i,
  input  logic [edp_pkg::NibW-1:0]         weight_nibble_i,
  input  logic [edp_pkg::ScaleW-1:0]       row_scale_i,
  input  logic [edp_pkg::ScaleW-1:0]       col_scale_i,
  output logic signed [edp_pkg::SumW-1:0]  dot_sum_o,
  output logic [edp_pkg::HalfW-1:0]        half_result_o
);

  localparam int unsigned LoW  = edp_pkg::LoW;
  localparam int unsigned HiW  = edp_pkg::HiW;
  localparam int unsigned SumW = edp_pkg::SumW;

  edp_pkg::wsplit_t        ws;
  logic signed [7:0]       p_lo;
  logic signed [5:0]       p_hi;
  logic signed [LoW-1:0]   acc_lo_d, acc_lo_q;
  logic signed [HiW-1:0]   acc_hi_d, acc_hi_q;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic [31:0]             row_q, col_q;

  always_comb begin
    ws       = edp_pkg::decode_weight(weight_nibble_i);
    p_lo     = 8'(act_i * ws.lo);
    p_hi     = 6'(act_i * ws.hi);
    acc_lo_d = acc_lo_q + LoW'(p_lo);
    acc_hi_d = acc_hi_q + HiW'(p_hi);
    sum_d    = SumW'(acc_lo_d) + {acc_hi_d, 3'b000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (cmd_i.last_en) begin
      acc_lo_q <= '0;
      acc_hi_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_lo_q <= acc_lo_d;
      acc_hi_q <= acc_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.last_en) begin
      sum_q <= sum_d;
      row_q <= row_scale_i;
      col_q <= col_scale_i;
    end
  end

  // operand select: row*col first, then sum*scale
  edp_pkg::fop_t   op_a, op_b;
  logic [31:0]     mul_res;
  logic [SumW-1:0] sum_mag;

  always_comb begin
    sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
    if (cmd_i.op_sel) begin
      op_a.sign    = sum_q[SumW-1];
      op_a.exp     = edp_pkg::IntExp;
      op_a.mant    = edp_pkg::MantW'(sum_mag);
      op_a.is_nan  = 1'b0;
      op_a.is_inf  = 1'b0;
      op_a.is_zero = (sum_q == '0);
      op_b         = edp_pkg::unpack_f32(mul_res);
    end else begin
      op_a = edp_pkg::unpack_f32(row_q);
      op_b = edp_pkg::unpack_f32(col_q);
    end
  end

  edp_fmul u_fmul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (mul_res)
  );

  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic [15:0]        s;
    logic [7:0]         ex;
    logic [23:0]        man;
    logic signed [9:0]  e;
    logic [4:0]         sh;
    logic [23:0]        q, rem, half;
    logic [15:0]        r;
    s   = {b[31], 15'd0};
    ex  = b[30:23];
    man = {1'b0, b[22:0]};
    e   = $signed({2'b00, ex}) - 10'sd112;
    sh  = '0;
    q   = '0;
    rem = '0;
    half = '0;
    priority if (ex == 8'hFF) begin
      r = (man != '0) ? 16'h7E00 : (s | 16'h7C00);
    end else if (e >= 10'sd31) begin
      r = s | 16'h7C00;
    end else if (e < -10'sd10) begin
      r = s;
    end else if (e <= 10'sd0) begin
      man  = man | 24'h80_0000;
      sh   = 5'(10'sd14 - e);
      q    = man >> sh;
      rem  = man & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 5'd1);
      if ((rem > half) || ((rem == half) && q[0])) begin
        q = q + 24'd1;
      end
      r = s | q[15:0];
    end else begin
      q   = {9'd0, e[4:0], man[22:13]};
      rem = {11'd0, man[12:0]};
      if ((rem > 24'h1000) || ((rem == 24'h1000) && q[0])) begin
        q = q + 24'd1;
      end
      r = s | q[15:0];
    end
    return r;
  endfunction

  logic signed [SumW-1:0] out_sum_q;
  logic [15:0]            out_half_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sum_q  <= sum_q;
      out_half_q <= to_half(mul_res);
    end
  end

  assign dot_sum_o     = out_sum_q;
  assign half_result_o = out_half_q;

endmodule

/* hw/rtl/edp_ctrl.sv */
// ----------------------------------------------------------------------------
// edp_ctrl
// sequencer for accumulation, the two float multiplies and result handoff
// ----------------------------------------------------------------------------
module edp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  edp_pkg::stat_t stat_i,
  output edp_pkg::cmd_t cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_A1   = 8'b0000_0010,
    ST_A2   = 8'b0000_0100,
    ST_A3   = 8'b0000_1000,
    ST_B1   = 8'b0001_0000,
    ST_B2   = 8'b0010_0000,
    ST_B3   = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   fire;

  // a last item needs the output register free
  assign in_ready_o = (state_q == ST_IDLE) && (!stat_i.in_last || !out_valid_q);
  assign fire       = stat_i.in_valid && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (fire && stat_i.in_last) state_d = ST_A1;
      ST_A1:   state_d = ST_A2;
      ST_A2:   state_d = ST_A3;
      ST_A3:   state_d = ST_B1;
      ST_B1:   state_d = ST_B2;
      ST_B2:   state_d = ST_B3;
      ST_B3:   state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && stat_i.out_ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_DONE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.acc_en   = fire;
  assign cmd_o.last_en  = fire && stat_i.in_last;
  assign cmd_o.op_sel   = (state_q == ST_B1);
  assign cmd_o.load_out = (state_q == ST_DONE);
  assign out_valid_o    = out_valid_q;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !out_valid_q) else $error("result overwritten");
  a_valid_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE)) else $error("spurious result");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stat_i.in_last) |=> (state_q == ST_A1)) else $error("last not sequenced");
`endif

endmodule

/* hw/rtl/e2m1_int4_scaled_dot_product_unit.sv */
// ----------------------------------------------------------------------------
// e2m1_int4_scaled_dot_product_unit
// e2m1 weight by int4 activation dot product with float32 scaling to binary16
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          transaction
//  in_i     in   act, weight_nibble, last, row_scale, col_scale   one element
//  out_o    out  dot_sum, half_result                             one result
//
//  non-last elements are taken one per cycle while the sequencer is idle
//  a last element starts the scaling (two passes through the shared
//  3-stage float multiplier plus the half conversion) before the next is taken
//  a last element waits while the previous result is still not taken
//  reset clears the accumulators, sequencer and result valid
// ----------------------------------------------------------------------------
module e2m1_int4_scaled_dot_product_unit (
  input logic       clk_i,
  input logic       rst_ni,
  edp_in_if.sink    in_i,
  edp_out_if.source out_o
);

  edp_pkg::cmd_t  cmd;
  edp_pkg::stat_t stat;

  assign stat.in_valid  = in_i.valid;
  assign stat.in_last   = in_i.last;
  assign stat.out_ready = out_o.ready;

  edp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  edp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .act_i           (in_i.act),
    .weight_nibble_i (in_i.weight_nibble),
    .row_scale_i     (in_i.row_scale),
    .col_scale_i     (in_i.col_scale),
    .dot_sum_o       (out_o.dot_sum),
    .half_result_o   (out_o.half_result)
  );

endmodule
